// ----- rtl/tsg_pkg.sv -----
package tsg_pkg;

  // Field widths
  localparam int unsigned ModeW     = 2;
  localparam int unsigned IdW       = 8;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned CountW    = 8;
  localparam int unsigned ProgW     = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 24;

  localparam int unsigned ContactLimitDef = 255;

  // Divider sizing: remainder holds 2000*v + t, divisor starts at 2t << 9
  localparam int unsigned RemW      = 27;
  localparam int unsigned DivW      = 26;
  localparam int unsigned DivSteps  = 10;
  localparam int unsigned StepW     = 4;

  localparam logic [ProgW-1:0] ProgMax = 10'd1000;
  localparam logic [RemW-1:0]  NumScale = 27'd2000;

  // Event codes
  typedef enum logic [ModeW-1:0] {
    MODE_DOWN   = 2'd0,
    MODE_MOTION = 2'd1,
    MODE_UP     = 2'd2,
    MODE_CANCEL = 2'd3
  } mode_t;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_TOWARD_BOTTOM = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ARM_DISTANCE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FULL_TRAVEL   = 2'd2;

  localparam logic [CfgDataW-1:0] ArmDistanceRst = 16'd64;
  localparam logic [CfgDataW-1:0] FullTravelRst  = 16'd400;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

// ----- rtl/touch_swipe_gesture_detector.sv -----
// Swipe recognizer for touch events with one owning contact. Each input
// transaction (mode in in_tuser: down, motion, up, cancel) updates the
// contact count, owner, start point and the armed/cancelled flags, and
// yields exactly one result transaction carrying launch, progress (0..1000
// thousandths of full_travel, rounded half up), armed, cancelled and the
// active contact count. A motion event that needs a progress division
// runs accept, numerator setup, ten restoring compare/subtract steps on
// the shared subtractor and result load; other events go from accept
// straight to result load; in_tready is low meanwhile. A result that is not
// taken holds the block in its result-load step. Configuration writes on
// the cfg_ channel are always ready and take effect at once.
module touch_swipe_gesture_detector #(
  parameter int unsigned CONTACT_LIMIT = tsg_pkg::ContactLimitDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: contact_id[7:0], x_pos[23:8], y_pos[39:24]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tsg_pkg::InDataW-1:0]   in_tdata,
  // in_tuser: mode[1:0]
  input  logic [tsg_pkg::ModeW-1:0]     in_tuser,
  // out_tdata: launch[0], progress[10:1], is_armed[11], is_cancelled[12],
  // active_contacts[20:13], zero pad[23:21]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tsg_pkg::OutDataW-1:0]  out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tsg_pkg::CfgDataW-1:0]  cfg_data
);

  // Effective saturation point of the 8-bit count
  localparam int unsigned LimitInt = (CONTACT_LIMIT < 255) ? CONTACT_LIMIT : 255;
  localparam logic [tsg_pkg::CountW-1:0] Limit = tsg_pkg::CountW'(LimitInt);

  // Configuration
  logic                          toward_bottom_r;
  logic [tsg_pkg::CfgDataW-1:0]  arm_distance_r;
  logic [tsg_pkg::CfgDataW-1:0]  full_travel_r;

  // Gesture state
  logic [tsg_pkg::CountW-1:0]    count_r, count_nxt;
  logic [tsg_pkg::IdW-1:0]       owner_r, owner_nxt;
  logic signed [tsg_pkg::CoordW-1:0] start_x_r, start_x_nxt;
  logic signed [tsg_pkg::CoordW-1:0] start_y_r, start_y_nxt;
  logic                          armed_r, armed_nxt;
  logic                          cancel_r, cancel_nxt;
  logic                          launch_r, launch_nxt;

  // Sequencer and divider
  tsg_pkg::state_t               state_r;
  logic [tsg_pkg::StepW-1:0]     step_r;
  logic [tsg_pkg::CoordW-1:0]    v_r;
  logic [tsg_pkg::RemW-1:0]      rem_r;
  logic [tsg_pkg::DivW-1:0]      div_r;
  logic [tsg_pkg::ProgW-1:0]     quo_r;

  logic                          out_valid_r;
  logic [tsg_pkg::OutDataW-1:0]  out_data_r;

  // Event decode
  tsg_pkg::mode_t                mode;
  logic [tsg_pkg::IdW-1:0]       ev_id;
  logic signed [tsg_pkg::CoordW-1:0] ev_x, ev_y;
  logic                          in_fire;

  logic signed [tsg_pkg::CoordW:0]   travel;
  logic signed [tsg_pkg::CoordW:0]   dx;
  logic [tsg_pkg::CoordW:0]          adx;
  logic                          prog_zero, prog_full;

  // Shared compare/subtract unit
  logic [tsg_pkg::RemW:0]        sub_diff;
  logic                          sub_ge;

  assign mode    = tsg_pkg::mode_t'(in_tuser);
  assign ev_id   = in_tdata[7:0];
  assign ev_x    = signed'(in_tdata[23:8]);
  assign ev_y    = signed'(in_tdata[39:24]);
  assign in_tready = (state_r == tsg_pkg::S_IDLE);
  assign in_fire = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign travel = toward_bottom_r ? ({ev_y[15], ev_y} - {start_y_r[15], start_y_r})
                                  : ({start_y_r[15], start_y_r} - {ev_y[15], ev_y});
  assign dx  = {ev_x[15], ev_x} - {start_x_r[15], start_x_r};
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);

  // Progress short cuts: zero cases, and travel at or past full_travel clamps
  assign prog_zero = (mode != tsg_pkg::MODE_MOTION) || (count_r == '0) || cancel_r ||
                     (full_travel_r == '0) || (travel <= 0);
  assign prog_full = ($signed({travel[16], travel}) >= $signed({2'b00, full_travel_r}));

  assign sub_diff = {1'b0, rem_r} - {2'b00, div_r};
  assign sub_ge   = !sub_diff[tsg_pkg::RemW];

  // Next gesture state for the accepted event
  always_comb begin
    count_nxt   = count_r;
    owner_nxt   = owner_r;
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    armed_nxt   = armed_r;
    cancel_nxt  = cancel_r;
    launch_nxt  = 1'b0;
    unique case (mode)
      tsg_pkg::MODE_DOWN: begin
        if (count_r != '0) begin
          if (count_r < Limit) count_nxt = count_r + 8'd1;
          cancel_nxt = 1'b1;
          armed_nxt  = 1'b0;
        end else begin
          count_nxt   = 8'd1;
          owner_nxt   = ev_id;
          start_x_nxt = ev_x;
          start_y_nxt = ev_y;
          armed_nxt   = 1'b0;
          cancel_nxt  = 1'b0;
        end
      end
      tsg_pkg::MODE_MOTION: begin
        if ((count_r != '0) && !cancel_r && (ev_id == owner_r)) begin
          armed_nxt = ($signed({travel[16], travel}) >= $signed({2'b00, arm_distance_r})) &&
                      ($signed({travel[16], travel}) > $signed({1'b0, adx}));
        end
      end
      tsg_pkg::MODE_UP: begin
        if (count_r != '0) begin
          launch_nxt = (count_r == 8'd1) && (ev_id == owner_r) && armed_r && !cancel_r;
          count_nxt  = count_r - 8'd1;
          if (count_r == 8'd1) begin
            owner_nxt   = '0;
            start_x_nxt = '0;
            start_y_nxt = '0;
            armed_nxt   = 1'b0;
            cancel_nxt  = 1'b0;
          end
        end
      end
      tsg_pkg::MODE_CANCEL: begin
        cancel_nxt = 1'b1;
        armed_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toward_bottom_r <= 1'b0;
      arm_distance_r  <= tsg_pkg::ArmDistanceRst;
      full_travel_r   <= tsg_pkg::FullTravelRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsg_pkg::CFG_TOWARD_BOTTOM: toward_bottom_r <= cfg_data[0];
        tsg_pkg::CFG_ARM_DISTANCE:  arm_distance_r  <= cfg_data;
        tsg_pkg::CFG_FULL_TRAVEL:   full_travel_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Gesture state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      owner_r   <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
      armed_r   <= 1'b0;
      cancel_r  <= 1'b0;
    end else if (in_fire) begin
      count_r   <= count_nxt;
      owner_r   <= owner_nxt;
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
      armed_r   <= armed_nxt;
      cancel_r  <= cancel_nxt;
    end
  end

  // Sequencer: capture, numerator setup, restoring division, result load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsg_pkg::S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the result-load step handles out_valid_r itself
      if (out_valid_r && out_tready && (state_r != tsg_pkg::S_DONE)) out_valid_r <= 1'b0;
      unique case (state_r)
        tsg_pkg::S_IDLE: begin
          if (in_fire) begin
            launch_r <= launch_nxt;
            v_r      <= travel[15:0];
            priority if (prog_zero) begin
              quo_r   <= '0;
              state_r <= tsg_pkg::S_DONE;
            end else if (prog_full) begin
              quo_r   <= tsg_pkg::ProgMax;
              state_r <= tsg_pkg::S_DONE;
            end else begin
              state_r <= tsg_pkg::S_PREP;
            end
          end
        end
        tsg_pkg::S_PREP: begin
          // (2000v + t) / 2t, quotient known below 1001
          rem_r   <= 27'(v_r) * tsg_pkg::NumScale + 27'(full_travel_r);
          div_r   <= {full_travel_r, 10'd0};
          quo_r   <= '0;
          step_r  <= '0;
          state_r <= tsg_pkg::S_DIV;
        end
        tsg_pkg::S_DIV: begin
          if (sub_ge) rem_r <= sub_diff[tsg_pkg::RemW-1:0];
          quo_r  <= {quo_r[tsg_pkg::ProgW-2:0], sub_ge};
          div_r  <= div_r >> 1;
          step_r <= step_r + 4'd1;
          if (step_r == tsg_pkg::StepW'(tsg_pkg::DivSteps - 1)) state_r <= tsg_pkg::S_DONE;
        end
        tsg_pkg::S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {3'b000, count_r, cancel_r, armed_r, quo_r, launch_r};
            state_r     <= tsg_pkg::S_IDLE;
          end
        end
        default: state_r <= tsg_pkg::S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
